>>> rtl/jp_pkg.sv
package jp_pkg;

  // Circle capacity and derived widths
  localparam int MaxPeople = 64;
  localparam int IdxW      = $clog2(MaxPeople);
  localparam int CntW      = IdxW + 1;
  localparam int ShW       = $clog2(CntW);

  // Fixed field widths
  localparam int PersonW   = 7;

  // Status codes
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

endpackage

>>> rtl/jp_in_if.sv
interface jp_in_if;
  import jp_pkg::*;

  logic               valid;
  logic               ready;
  logic [PersonW-1:0] people_count;
  logic [PersonW-1:0] step_size;

  modport source (output valid, people_count, step_size, input ready);
  modport sink   (input valid, people_count, step_size, output ready);
endinterface

>>> rtl/jp_out_if.sv
interface jp_out_if;
  import jp_pkg::*;

  logic               valid;
  logic               ready;
  logic [PersonW-1:0] person;
  logic               status;
  logic               last;

  modport source (output valid, person, status, last, input ready);
  modport sink   (input valid, person, status, last, output ready);
endinterface

>>> rtl/jp_ram.sv
module jp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/josephus_permutation.sv
// Operation: a run of n people first fills the list, then per removal runs the modulo
//   steps, reads the removed slot, shifts the survivors after it down one slot and
//   emits the removed person, held back while the output register waits on out_ready.
// Throughput: one run at a time; in_ready is high only between runs. A full run
//   of 64 people at step 1 is dominated by the list shift.
// An invalid request passes through the error state, which loads its error word into
//   the output register once that register holds no undrained word.
// Reset (rst_n, synchronous, active low) clears the sequencer, counters and output valid.
module josephus_permutation (
  input  logic      clk,
  input  logic      rst_n,
  jp_in_if.sink     in_ch,
  jp_out_if.source  out_ch
);
  import jp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_FILL,
    ST_MOD,
    ST_RD,
    ST_GET,
    ST_SHIFT,
    ST_EMIT
  } state_t;

  state_t             state_r, state_nxt;

  // Run parameters and working state
  logic [CntW-1:0]    cnt_r, cnt_nxt;       // survivor count
  logic [IdxW-1:0]    idx_r, idx_nxt;       // index of the current removal
  logic [PersonW-1:0] m_r, m_nxt;           // step size
  logic [CntW-1:0]    k_r, k_nxt;           // fill counter
  logic [PersonW-1:0] rem_r, rem_nxt;       // modulo partial remainder
  logic [ShW-1:0]     sh_r, sh_nxt;         // modulo shift position
  logic [CntW-1:0]    rp_r, rp_nxt;         // shift read pointer
  logic [IdxW-1:0]    wa_r, wa_nxt;         // shift write pointer
  logic               pend_r, pend_nxt;     // read data in flight to be written back
  logic [PersonW-1:0] who_r, who_nxt;       // person removed this round

  // Output word register
  logic               out_valid_r, out_valid_nxt;
  logic [PersonW-1:0] out_person_r, out_person_nxt;
  logic               out_status_r, out_status_nxt;
  logic               out_last_r, out_last_nxt;

  // Survivor list memory
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [PersonW-1:0] ram_wdata;
  logic [IdxW-1:0]    ram_raddr;
  logic [PersonW-1:0] ram_rdata;

  // Shared compare-subtract unit of the modulo
  logic [PersonW+CntW-1:0] div_sh;
  logic                    div_ge;
  logic [PersonW-1:0]      rem_step;

  logic slot_free;
  logic req_bad;

  jp_ram #(
    .WIDTH (PersonW),
    .DEPTH (MaxPeople)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.person = out_person_r;
  assign out_ch.status = out_status_r;
  assign out_ch.last   = out_last_r;

  // The output register can take a new word when empty or being drained
  assign slot_free = !out_valid_r || out_ch.ready;

  // Zero step, step above count, or count above capacity
  assign req_bad = (in_ch.step_size == '0) || (in_ch.step_size > in_ch.people_count) ||
                   (in_ch.people_count > PersonW'(MaxPeople));

  // Restoring remainder: subtract count << sh when it fits, one shift position a cycle
  assign div_sh   = {{PersonW{1'b0}}, cnt_r} << sh_r;
  assign div_ge   = {{CntW{1'b0}}, rem_r} >= div_sh;
  assign rem_step = div_ge ? rem_r - div_sh[PersonW-1:0] : rem_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    m_nxt          = m_r;
    k_nxt          = k_r;
    rem_nxt        = rem_r;
    sh_nxt         = sh_r;
    rp_nxt         = rp_r;
    wa_nxt         = wa_r;
    pend_nxt       = pend_r;
    who_nxt        = who_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_person_nxt = out_person_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = wa_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (req_bad) begin
            state_nxt = ST_ERR;
          end else begin
            // Start a run: list fill first, index from zero
            state_nxt = ST_FILL;
            cnt_nxt   = CntW'(in_ch.people_count);
            m_nxt     = in_ch.step_size;
            k_nxt     = '0;
            idx_nxt   = '0;
          end
        end
      end

      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_person_nxt = '0;
          out_status_nxt = StatusErr;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      ST_FILL: begin
        // Write person k+1 at slot k
        ram_we    = 1'b1;
        ram_waddr = k_r[IdxW-1:0];
        ram_wdata = PersonW'(k_r + 1'b1);
        k_nxt     = k_r + 1'b1;
        if (CntW'(k_r + 1'b1) == cnt_r) begin
          state_nxt = ST_MOD;
          rem_nxt   = m_r - 1'b1;
          sh_nxt    = ShW'(CntW - 1);
        end
      end

      ST_MOD: begin
        rem_nxt = rem_step;
        if (sh_r == '0) begin
          idx_nxt   = rem_step[IdxW-1:0];
          state_nxt = ST_RD;
        end else begin
          sh_nxt = sh_r - 1'b1;
        end
      end

      ST_RD: begin
        ram_raddr = idx_r;
        state_nxt = ST_GET;
      end

      ST_GET: begin
        // Hold the removed person, then close the gap behind it
        who_nxt   = ram_rdata;
        rp_nxt    = CntW'(idx_r) + 1'b1;
        wa_nxt    = idx_r;
        pend_nxt  = 1'b0;
        state_nxt = ST_SHIFT;
      end

      ST_SHIFT: begin
        // Read slot rp while writing the previous read back one slot lower
        ram_raddr = rp_r[IdxW-1:0];
        if (rp_r < cnt_r) begin
          rp_nxt   = rp_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = ram_rdata;
          wa_nxt    = wa_r + 1'b1;
        end
        if (!(rp_r < cnt_r) && !pend_r) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_person_nxt = who_r;
          out_status_nxt = StatusOk;
          out_last_nxt   = (cnt_r == CntW'(1));
          cnt_nxt        = cnt_r - 1'b1;
          if (cnt_r == CntW'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MOD;
            rem_nxt   = PersonW'({1'b0, idx_r}) + m_r - 1'b1;
            sh_nxt    = ShW'(CntW - 1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      k_r         <= '0;
      sh_r        <= '0;
      rp_r        <= '0;
      wa_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      sh_r        <= sh_nxt;
      rp_r        <= rp_nxt;
      wa_r        <= wa_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // Payload, no reset needed
    m_r          <= m_nxt;
    rem_r        <= rem_nxt;
    who_r        <= who_nxt;
    out_person_r <= out_person_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

`ifndef ASSERT_OFF
  // An error word always names nobody and ends its run
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> (out_person_r == '0) && out_last_r)
    else $error("error word with nonzero person or without last");

  // Survivor count never exceeds the circle capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxPeople))
    else $error("survivor count above capacity");

  // Shift pointer stays within the survivors
  a_shift_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (rp_r <= cnt_r) && (CntW'(idx_r) < cnt_r))
    else $error("shift pointer beyond survivor count");

  // The final removal returns the block to idle with an empty circle
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && slot_free && (cnt_r == CntW'(1)) |=>
      (state_r == ST_IDLE) && (cnt_r == '0) && out_valid_r && out_last_r)
    else $error("run did not finish cleanly");
`endif

endmodule

>>> tb/sv/removal_order_check.sv
module removal_order_check (
  input  logic clk,
  input  logic rst_n,
  jp_in_if     in_mon,
  jp_out_if    out_mon,
  output int   mismatches,
  output int   removals_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import jp_pkg::*;

  typedef struct packed {
    logic [PersonW-1:0] person;
    logic               status;
    logic               last;
  } removal_t;

  removal_t removal_q[$];
  int       error_count = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Expand one run request into the elimination order it must produce.
  function automatic void predict_removals(input logic [PersonW-1:0] n,
                                           input logic [PersonW-1:0] m);
    logic [PersonW-1:0] circle [MaxPeople];
    int unsigned        alive;
    int unsigned        pos;
    removal_t           r;
    if (m == 0 || m > n || n > MaxPeople) begin
      r = '{person: '0, status: StatusErr, last: 1'b1};
      removal_q.push_back(r);
      return;
    end
    for (int k = 0; k < n; k++) circle[k] = PersonW'(k + 1);
    alive = n;
    pos   = 0;
    while (alive > 0) begin
      pos      = (pos + m - 1) % alive;
      r.person = circle[pos];
      for (int k = pos; k + 1 < alive; k++) circle[k] = circle[k + 1];
      alive--;
      r.status = StatusOk;
      r.last   = (alive == 0);
      removal_q.push_back(r);
    end
  endfunction

  always @(posedge clk) begin : watch
    removal_t due;
    if (!rst_n) begin
      removal_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        predict_removals(in_mon.people_count, in_mon.step_size);
      if (out_mon.valid && out_mon.ready) begin
        if (removal_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word person=%0d status=%0b last=%0b",
                                    out_mon.person, out_mon.status, out_mon.last));
        end else begin
          due = removal_q.pop_front();
          if (out_mon.person !== due.person)
            report_mismatch($sformatf("person %0d, expected %0d",
                                      out_mon.person, due.person));
          if (out_mon.status !== due.status)
            report_mismatch($sformatf("status %0b, expected %0b",
                                      out_mon.status, due.status));
          if (out_mon.last !== due.last)
            report_mismatch($sformatf("last %0b, expected %0b",
                                      out_mon.last, due.last));
        end
      end
    end
    mismatches       <= error_count;
    removals_pending <= removal_q.size();
  end

endmodule

>>> tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jp_pkg::*;

  localparam int ResetCycles    = 11;
  localparam int RandomPerPhase = 33;
  // Long output hold-off: starts once this many words have drained
  localparam int HoldAfterWords = 30;
  localparam int HoldCycles     = 700;
  // Error words trail acceptance through the error state; leave ample margin
  localparam int TailCycles     = 40;
  // Far above the time for 120 full-size runs with stalls
  localparam int WatchdogNs     = 48_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  int          mismatches;
  int          removals_pending;

  jp_in_if  in_ch ();
  jp_out_if out_ch ();

  josephus_permutation dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Watch both channels, predict the removal order and compare
  removal_order_check order_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatches       (mismatches),
    .removals_pending (removals_pending)
  );

  always #6 clk = ~clk;

  // Offer one run request; idle at random first, with junk on the fields,
  // then hold the word until the block takes it.
  task automatic send_run(input int n, input int m);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid        <= 1'b0;
      in_ch.people_count <= PersonW'($urandom);
      in_ch.step_size    <= PersonW'($urandom);
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.people_count <= PersonW'(n);
    in_ch.step_size    <= PersonW'(m);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Mostly small well-formed runs, a few large ones, some raw noise
  // that lands mostly on the error paths.
  task automatic send_random_run();
    int n;
    int m;
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      n = $urandom_range(127);
      m = $urandom_range(127);
    end else if (pick < 90) begin
      n = $urandom_range(12, 1);
      m = $urandom_range(n, 1);
    end else begin
      n = $urandom_range(MaxPeople, 13);
      m = $urandom_range(n, 1);
    end
    send_run(n, m);
  endtask

  initial begin : stimulus
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.people_count <= '0;
    in_ch.step_size    <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles lightly, receiver heavily
    sender_idle_pct   = 24;
    receiver_idle_pct = 58;

    // Directed: single person, zero step, empty circle, step past the count,
    // count past capacity, smallest and full circles, all-ones fields.
    send_run(1, 1);
    send_run(0, 0);
    send_run(0, 1);
    send_run(5, 0);
    send_run(5, 6);
    send_run(3, 127);
    send_run(2, 1);
    send_run(2, 2);
    send_run(7, 3);
    send_run(5, 5);
    send_run(10, 10);
    send_run(41, 3);
    send_run(64, 1);
    send_run(64, 64);
    send_run(64, 63);
    send_run(65, 1);
    send_run(100, 3);
    send_run(127, 127);
    send_run(64, 65);
    send_run(64, 0);
    repeat (RandomPerPhase) send_random_run();

    // Phase two: swap the idling rates
    sender_idle_pct   = 58;
    receiver_idle_pct = 24;
    repeat (RandomPerPhase) send_random_run();

    // Phase three: both sides at full rate
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    repeat (RandomPerPhase) send_random_run();
    in_ch.valid <= 1'b0;

    // Let the checker see the last request before polling its backlog
    @(posedge clk);
    while (removals_pending != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Result side: stall at random, and once hold off for a long stretch so the
  // block backs up and drops in_ready while a request is still offered.
  initial begin : drain
    int words_taken;
    bit held;
    words_taken = 0;
    held        = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) words_taken++;
      if (!held && words_taken == HoldAfterWords) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #(WatchdogNs);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> josephus_permutation.f
rtl/jp_pkg.sv
rtl/jp_in_if.sv
rtl/jp_out_if.sv
rtl/jp_ram.sv
rtl/josephus_permutation.sv
tb/sv/removal_order_check.sv
tb/sv/testbench.sv
